@@ rtl/core/etvs_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Volume swell shared definitions
// Register indexes, sequencer codes and the multiply-accumulate control
// bundle used by the volume swell core.
// ----------------------------------------------------------------------------
package etvs_pkg;

	// Output gain format, Q2.13.
	localparam int GAIN_FRAC = 13;
	localparam int GAIN_BITS = 15;

	// Configuration register indexes.
	localparam int CFG_IDX_BITS = 3;
	localparam logic [CFG_IDX_BITS-1:0] REG_ATTACK  = 3'd0;
	localparam logic [CFG_IDX_BITS-1:0] REG_RELEASE = 3'd1;
	localparam logic [CFG_IDX_BITS-1:0] REG_RATE    = 3'd2;
	localparam logic [CFG_IDX_BITS-1:0] REG_THRESH  = 3'd3;
	localparam logic [CFG_IDX_BITS-1:0] REG_MIX     = 3'd4;
	localparam logic [CFG_IDX_BITS-1:0] REG_GAIN    = 3'd5;

	// Sequencer states, one-hot.
	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_ISSUE = 4'b0010,
		ST_WAIT  = 4'b0100,
		ST_DONE  = 4'b1000
	} state_t;

	// Multiply-accumulate operations, issued in this order for every request.
	typedef enum logic [2:0] {
		OP_ENV_MAG   = 3'd0,
		OP_ENV_OLD   = 3'd1,
		OP_SWELL     = 3'd2,
		OP_BLEND     = 3'd3,
		OP_LEFT_T    = 3'd4,
		OP_LEFT_Y    = 3'd5,
		OP_RIGHT_T   = 3'd6,
		OP_RIGHT_Y   = 3'd7
	} op_t;

	// Control bundle from the sequencer to the multiply-accumulate unit.
	typedef struct packed {
		logic start;
		logic accum;
	} mac_ctl_t;

endpackage

@@ rtl/core/etvs_mac.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bit-serial multiply-accumulate unit
// Multiplies a parallel operand by a serial operand one bit per cycle, adding
// the partial products into an accumulator that is preloaded or kept.
// ----------------------------------------------------------------------------
module etvs_mac #(
	parameter int WA   = 24,
	parameter int WB   = 17,
	parameter int WACC = 42
) (
	input  logic                clk,
	input  logic                arst_n,
	input  etvs_pkg::mac_ctl_t  ctl,
	input  logic [WA-1:0]       a,
	input  logic [WB-1:0]       b,
	input  logic [WACC-1:0]     init,
	output logic                done,
	output logic [WACC-1:0]     acc
);
	import etvs_pkg::*;

	localparam int CW = $clog2(WB + 1);

	logic [WACC-1:0] a_q;
	logic [WACC-1:0] acc_q;
	logic [WB-1:0]   b_q;
	logic [CW-1:0]   cnt_q;
	logic            busy_q;
	logic            done_q;

	// Bit counter: one multiplier bit is consumed each busy cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (ctl.start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(WB);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Shift-add datapath, least significant multiplier bit first.
	always_ff @(posedge clk) begin
		if (ctl.start) begin
			a_q <= WACC'(a);
			b_q <= b;
			if (!ctl.accum) begin
				acc_q <= init;
			end
		end else if (busy_q) begin
			if (b_q[0]) begin
				acc_q <= acc_q + a_q;
			end
			a_q <= a_q << 1;
			b_q <= b_q >> 1;
		end
	end

	assign done = done_q;
	assign acc  = acc_q;

endmodule

@@ rtl/core/envelope_triggered_volume_swell.sv @@
`timescale 1ns / 1ps
// Flow: a stereo pair is taken only while the sequencer is idle; the single bit-serial
// multiply-accumulate unit runs eight products one after another, and a new pair is
// not accepted until the previous result has been loaded into the output register.
// Reset: asynchronous and active low; the envelope clears, the swell gain opens to unity
// and the configuration and control registers return to their defaults; the working
// and output data registers are not reset.
// ----------------------------------------------------------------------------
// Envelope triggered volume swell
// Peak envelope follower on the left channel restarts a one-pole gain ramp at
// each onset; both channels are blended, scaled by the output gain and clipped.
// ----------------------------------------------------------------------------
module envelope_triggered_volume_swell #(
	parameter  int SAMPLE_BITS = 24,
	parameter  int COEFF_BITS  = 16,
	localparam int TD_W  = ((2 * SAMPLE_BITS + 7) / 8) * 8,
	localparam int CFG_A = (SAMPLE_BITS - 1 > COEFF_BITS + 1) ? SAMPLE_BITS - 1 : COEFF_BITS + 1,
	localparam int CFG_W = (CFG_A > etvs_pkg::GAIN_BITS) ? CFG_A : etvs_pkg::GAIN_BITS
) (
	input  logic                             clk,
	input  logic                             arst_n,
	// Input stream.
	input  logic                             s_tvalid,
	output logic                             s_tready,
	input  logic [TD_W-1:0]                  s_tdata,  // left_in, right_in
	// Output stream.
	output logic                             m_tvalid,
	input  logic                             m_tready,
	output logic [TD_W-1:0]                  m_tdata,  // left_out, right_out
	output logic                             m_tuser,  // note_onset
	// Configuration write port.
	input  logic                             cfg_we,
	input  logic [etvs_pkg::CFG_IDX_BITS-1:0] cfg_index,
	input  logic [CFG_W-1:0]                 cfg_data
);
	import etvs_pkg::*;

	localparam int SB     = SAMPLE_BITS;
	localparam int CB     = COEFF_BITS;
	localparam int MAG_W  = SB - 1;
	localparam int MIX_W  = CB + 1;
	localparam int WA     = (SB > CB + 1) ? SB : CB + 1;
	localparam int WB     = (CB + 1 > GAIN_BITS) ? CB + 1 : GAIN_BITS;
	localparam int WACC   = WA + WB + 1;
	localparam int PROD_W = WACC - CB;
	localparam int Y_W    = WACC - GAIN_FRAC;

	localparam logic [WACC-1:0]  HALF_A  = WACC'(1) << (CB - 1);
	localparam logic [WACC-1:0]  GHALF_A = WACC'(1) << (GAIN_FRAC - 1);
	localparam logic [MIX_W-1:0] ONE_Q   = MIX_W'(1) << CB;
	localparam logic [MAG_W-1:0] MAG_MAX = '1;
	localparam logic [SB-1:0]    NEG_MAG = SB'(1) << (SB - 1);

	// Defaults are given for Q0.16 and Q1.23 and rescaled to the chosen widths.
	localparam logic [CB-1:0]    ATT_RST = CB'((64'd65010 << CB) >> 16);
	localparam logic [CB-1:0]    REL_RST = CB'((64'd65527 << CB) >> 16);
	localparam logic [CB-1:0]    RATE_RST = CB'((64'd3 << CB) >> 16);
	localparam logic [MAG_W-1:0] THR_RST = MAG_W'((64'd83886 << (SB - 1)) >> 23);
	localparam logic [GAIN_BITS-1:0] GAIN_RST = GAIN_BITS'(8192);

	// Configuration registers.
	logic [CB-1:0]        att_q;
	logic [CB-1:0]        rel_q;
	logic [CB-1:0]        rate_q;
	logic [MAG_W-1:0]     thr_q;
	logic [MIX_W-1:0]     mix_q;
	logic [GAIN_BITS-1:0] og_q;

	// Control and algorithm state.
	state_t           state_q;
	op_t              op_q;
	logic [MAG_W-1:0] env_q;
	logic [MIX_W-1:0] sg_q;
	logic             m_tvalid_q;

	// Per-request working registers.
	logic [SB-1:0]    absl_q;
	logic [SB-1:0]    absr_q;
	logic             negl_q;
	logic             negr_q;
	logic [MAG_W-1:0] mag_q;
	logic [CB-1:0]    c_q;
	logic [MIX_W-1:0] blend_q;
	logic [SB-1:0]    t_q;
	logic [SB-1:0]    resl_q;
	logic [SB-1:0]    resr_q;
	logic             onset_q;
	logic [SB-1:0]    outl_q;
	logic [SB-1:0]    outr_q;
	logic             outo_q;

	// Multiply-accumulate interface.
	mac_ctl_t         mac_ctl;
	logic [WA-1:0]    mac_a;
	logic [WB-1:0]    mac_b;
	logic [WACC-1:0]  mac_init;
	logic             mac_done;
	logic [WACC-1:0]  mac_acc;

	// Combinational helpers.
	logic             accept;
	logic             out_free;
	logic [SB-1:0]    left_in;
	logic [SB-1:0]    right_in;
	logic [SB-1:0]    abs_l;
	logic [SB-1:0]    abs_r;
	logic [MAG_W-1:0] mag;
	logic [MIX_W-1:0] mix_sat;
	logic [PROD_W-1:0] prod;
	logic [MAG_W-1:0] env_new;
	logic             onset;
	logic [CB+1:0]    sg_sum;
	logic [MIX_W-1:0] sg_new;
	logic [Y_W-1:0]   y;
	logic [Y_W-1:0]   y_lim;
	logic             sel_neg;
	logic [SB-1:0]    y_sat;
	logic [SB-1:0]    y_res;

	assign accept   = s_tvalid && s_tready;
	assign s_tready = (state_q == ST_IDLE);
	assign out_free = !m_tvalid_q || m_tready;

	// Input unpacking, magnitudes and coefficient choice at accept time.
	always_comb begin
		left_in  = s_tdata[SB-1:0];
		right_in = s_tdata[2*SB-1:SB];
		abs_l    = left_in[SB-1] ? (~left_in + 1'b1) : left_in;
		abs_r    = right_in[SB-1] ? (~right_in + 1'b1) : right_in;
		mag      = abs_l[SB-1] ? MAG_MAX : abs_l[MAG_W-1:0];
	end

	assign mix_sat = (mix_q > ONE_Q) ? ONE_Q : mix_q;

	// Operand selection for the current operation.
	always_comb begin
		mac_ctl.start = (state_q == ST_ISSUE);
		mac_ctl.accum = 1'b0;
		mac_a         = '0;
		mac_b         = '0;
		mac_init      = HALF_A;
		case (op_q)
			OP_ENV_MAG: begin
				mac_a = WA'(mag_q);
				mac_b = WB'(ONE_Q - MIX_W'(c_q));
			end
			OP_ENV_OLD: begin
				mac_a         = WA'(env_q);
				mac_b         = WB'(c_q);
				mac_ctl.accum = 1'b1;
			end
			OP_SWELL: begin
				mac_a = WA'(ONE_Q - sg_q);
				mac_b = WB'(rate_q);
			end
			OP_BLEND: begin
				mac_a    = WA'(mix_sat);
				mac_b    = WB'(sg_q);
				mac_init = HALF_A + (WACC'(ONE_Q - mix_sat) << CB);
			end
			OP_LEFT_T: begin
				mac_a = WA'(absl_q);
				mac_b = WB'(blend_q);
			end
			OP_LEFT_Y: begin
				mac_a    = WA'(t_q);
				mac_b    = WB'(og_q);
				mac_init = GHALF_A;
			end
			OP_RIGHT_T: begin
				mac_a = WA'(absr_q);
				mac_b = WB'(blend_q);
			end
			OP_RIGHT_Y: begin
				mac_a    = WA'(t_q);
				mac_b    = WB'(og_q);
				mac_init = GHALF_A;
			end
			default: begin
				mac_a = '0;
			end
		endcase
	end

	etvs_mac #(
		.WA   (WA),
		.WB   (WB),
		.WACC (WACC)
	) u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (mac_ctl),
		.a      (mac_a),
		.b      (mac_b),
		.init   (mac_init),
		.done   (mac_done),
		.acc    (mac_acc)
	);

	// Post-processing of a finished product.
	always_comb begin
		prod    = mac_acc[WACC-1:CB];
		env_new = (prod > PROD_W'(MAG_MAX)) ? MAG_MAX : prod[MAG_W-1:0];
		onset   = (env_q < thr_q) && (env_new >= thr_q);
		sg_sum  = (CB + 2)'(sg_q) + prod[CB+1:0];
		sg_new  = (sg_sum > (CB + 2)'(ONE_Q)) ? ONE_Q : sg_sum[MIX_W-1:0];
		y       = mac_acc[WACC-1:GAIN_FRAC];
		sel_neg = (op_q == OP_LEFT_Y) ? negl_q : negr_q;
		y_lim   = sel_neg ? Y_W'(NEG_MAG) : Y_W'(MAG_MAX);
		y_sat   = (y > y_lim) ? y_lim[SB-1:0] : y[SB-1:0];
		y_res   = sel_neg ? (~y_sat + 1'b1) : y_sat;
	end

	// Configuration, sequencer and algorithm state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			att_q      <= ATT_RST;
			rel_q      <= REL_RST;
			rate_q     <= RATE_RST;
			thr_q      <= THR_RST;
			mix_q      <= ONE_Q;
			og_q       <= GAIN_RST;
			state_q    <= ST_IDLE;
			op_q       <= OP_ENV_MAG;
			env_q      <= '0;
			sg_q       <= ONE_Q;
			m_tvalid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_ATTACK:  att_q  <= cfg_data[CB-1:0];
					REG_RELEASE: rel_q  <= cfg_data[CB-1:0];
					REG_RATE:    rate_q <= cfg_data[CB-1:0];
					REG_THRESH:  thr_q  <= cfg_data[MAG_W-1:0];
					REG_MIX:     mix_q  <= cfg_data[MIX_W-1:0];
					REG_GAIN:    og_q   <= cfg_data[GAIN_BITS-1:0];
					default: ;
				endcase
			end

			// The result is valid from the load of a finished pair until it is taken.
			if ((state_q == ST_DONE) && out_free) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end

			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						op_q    <= OP_ENV_MAG;
						state_q <= ST_ISSUE;
					end
				end
				ST_ISSUE: begin
					state_q <= ST_WAIT;
				end
				ST_WAIT: begin
					if (mac_done) begin
						if (op_q == OP_ENV_OLD) begin
							env_q <= env_new;
							if (onset) begin
								sg_q <= '0;
							end
						end
						if (op_q == OP_SWELL) begin
							sg_q <= sg_new;
						end
						if (op_q == OP_RIGHT_Y) begin
							state_q <= ST_DONE;
						end else begin
							op_q    <= op_t'(op_q + 3'd1);
							state_q <= ST_ISSUE;
						end
					end
				end
				ST_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Working registers and the output register.
	always_ff @(posedge clk) begin
		if (accept) begin
			absl_q <= abs_l;
			absr_q <= abs_r;
			negl_q <= left_in[SB-1];
			negr_q <= right_in[SB-1];
			mag_q  <= mag;
			c_q    <= (mag > env_q) ? att_q : rel_q;
		end
		if ((state_q == ST_WAIT) && mac_done) begin
			case (op_q)
				OP_ENV_OLD: onset_q <= onset;
				OP_BLEND:   blend_q <= prod[MIX_W-1:0];
				OP_LEFT_T:  t_q     <= prod[SB-1:0];
				OP_LEFT_Y:  resl_q  <= y_res;
				OP_RIGHT_T: t_q     <= prod[SB-1:0];
				OP_RIGHT_Y: resr_q  <= y_res;
				default: ;
			endcase
		end
		if ((state_q == ST_DONE) && out_free) begin
			outl_q <= resl_q;
			outr_q <= resr_q;
			outo_q <= onset_q;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = TD_W'({outr_q, outl_q});
	assign m_tuser  = outo_q;

endmodule

@@ rtl/core/etvs_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Volume swell port checker
// Watches the stream and configuration ports of the volume swell core and
// flags timing that the sequencer must never produce.
// ----------------------------------------------------------------------------
module etvs_checker #(
	parameter  int SAMPLE_BITS = 24,
	parameter  int COEFF_BITS  = 16,
	localparam int TD_W  = ((2 * SAMPLE_BITS + 7) / 8) * 8,
	localparam int CFG_A = (SAMPLE_BITS - 1 > COEFF_BITS + 1) ? SAMPLE_BITS - 1 : COEFF_BITS + 1,
	localparam int CFG_W = (CFG_A > etvs_pkg::GAIN_BITS) ? CFG_A : etvs_pkg::GAIN_BITS
) (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              s_tvalid,
	input logic                              s_tready,
	input logic [TD_W-1:0]                   s_tdata,
	input logic                              m_tvalid,
	input logic                              m_tready,
	input logic [TD_W-1:0]                   m_tdata,
	input logic                              m_tuser,
	input logic                              cfg_we,
	input logic [etvs_pkg::CFG_IDX_BITS-1:0] cfg_index,
	input logic [CFG_W-1:0]                  cfg_data
);
	import etvs_pkg::*;

	// A stalled result holds its value.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result changed while stalled");

	// Once a request is taken the core stays busy and does not take another one straight away.
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready ##1 !s_tready)
		else $error("request taken while the previous one is in progress");

	// A new result never appears right after a request is taken.
	a_no_shortcut: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> !$past(s_tvalid && s_tready))
		else $error("result appeared without the multiply sequence");

	// An accepted request carries known sample bits.
	a_req_known: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |-> !$isunknown(s_tdata))
		else $error("request with unknown sample bits");

	// Registers are written only while the core is idle, with known index and data.
	a_cfg_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_we |-> s_tready && !$isunknown({cfg_index, cfg_data}))
		else $error("register written while a request is in progress");

endmodule

bind envelope_triggered_volume_swell etvs_checker #(
	.SAMPLE_BITS (SAMPLE_BITS),
	.COEFF_BITS  (COEFF_BITS)
) u_etvs_checker (.*);
